@@ sv/ddpsc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Differential drive straight control package
// Shared types and fixed-point constants of the straight-line drive
// controller.
// ----------------------------------------------------------------------------
package ddpsc_pkg;

  // Request opcodes.
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_DRIVE = 2'd1,
    OP_STOP  = 2'd2,
    OP_TURN  = 2'd3
  } op_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_KP     = 3'd0,
    CFG_KD     = 3'd1,
    CFG_FACTOR = 3'd2,
    CFG_STEP   = 3'd3,
    CFG_DSCALE = 3'd4,
    CFG_TSCALE = 3'd5
  } cfg_idx_e;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned SCALE_W    = 16;
  localparam int unsigned STEP_W     = 15;
  localparam int unsigned DUTY_W     = 8;
  localparam int unsigned SETPT_W    = 8;
  localparam int unsigned ANGLE_W    = 16;
  localparam int unsigned RAMP_W     = 16;
  localparam int unsigned MUL_B_W    = 17;

  // Clamped Q4.12 duty fits in this many signed bits.
  localparam int unsigned CLAMP_W    = 20;

  localparam int unsigned Q12_FRAC   = 12;
  localparam int unsigned Q14_FRAC   = 14;
  localparam int unsigned Q16_FRAC   = 16;
  localparam int unsigned Q8_FRAC    = 8;
  localparam int unsigned BASE_SHIFT = 4;

  localparam int          DUTY_LIMIT     = 100;
  localparam int          DUTY_LIMIT_Q12 = DUTY_LIMIT * 4096;

  // Reset values of the configuration registers.
  localparam logic [SCALE_W-1:0] FACTOR_RST = 16'd16384;
  localparam logic [STEP_W-1:0]  STEP_RST   = 15'd256;
  localparam logic [SCALE_W-1:0] DSCALE_RST = 16'd1000;
  localparam logic [SCALE_W-1:0] TSCALE_RST = 16'd4096;

  // Sequencer states.
  typedef enum logic [16:0] {
    ST_IDLE  = 17'b00000000000000001,
    ST_SUM   = 17'b00000000000000010,
    ST_HALF  = 17'b00000000000000100,
    ST_MDIST = 17'b00000000000001000,
    ST_MERR  = 17'b00000000000010000,
    ST_ERRA  = 17'b00000000000100000,
    ST_ERRB  = 17'b00000000001000000,
    ST_DIFF  = 17'b00000000010000000,
    ST_MKP   = 17'b00000000100000000,
    ST_MKD   = 17'b00000001000000000,
    ST_PD    = 17'b00000010000000000,
    ST_DUTYL = 17'b00000100000000000,
    ST_DUTYR = 17'b00001000000000000,
    ST_TMUL  = 17'b00010000000000000,
    ST_TDIV  = 17'b00100000000000000,
    ST_TSAT  = 17'b01000000000000000,
    ST_FIN   = 17'b10000000000000000
  } state_e;

endpackage

@@ sv/differential_drive_pd_straight_control.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Differential drive straight-line PD controller
// A drive tick walks through the distance, error, PD and duty states, a turn
// through its target states; every other request goes straight to finish.
// A request is taken only after the last one is finished; a single shared
// multiplier, run by the sequencer, serves all the products.
// Reset: asynchronous, active low; mode idle, state zero, registers default.
// ----------------------------------------------------------------------------
module differential_drive_pd_straight_control #(
  parameter int unsigned POSITION_BITS = 24
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,

  // Configuration write channel.
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [ddpsc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [ddpsc_pkg::CFG_DATA_W-1:0]      cfg_data_i,

  // Request channel.
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  ddpsc_pkg::op_e                        opcode_i,
  input  logic signed [POSITION_BITS-1:0]       left_position_i,
  input  logic signed [POSITION_BITS-1:0]       right_position_i,
  input  logic signed [ddpsc_pkg::SETPT_W-1:0]  duty_setpoint_i,
  input  logic signed [ddpsc_pkg::ANGLE_W-1:0]  turn_angle_i,

  // Result channel.
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [ddpsc_pkg::DUTY_W-1:0]   left_duty_o,
  output logic signed [ddpsc_pkg::DUTY_W-1:0]   right_duty_o,
  output logic                                  drive_active_o,
  output logic signed [POSITION_BITS-1:0]       travelled_distance_o,
  output logic signed [POSITION_BITS-1:0]       balance_error_o,
  output logic signed [POSITION_BITS-1:0]       left_turn_target_o,
  output logic signed [POSITION_BITS-1:0]       right_turn_target_o,
  output logic                                  current_mode_o
);

  import ddpsc_pkg::*;

  localparam int unsigned P      = POSITION_BITS;
  // Multiplier operand A holds the negated half sum and the error change.
  localparam int unsigned MA     = P + 2;
  localparam int unsigned PROD_W = MA + MUL_B_W;
  // Working width of the datapath; holds every intermediate sum.
  localparam int unsigned PW     = P + 20;

  localparam logic signed [PW-1:0] POS_MAX =
    signed'({{(PW-P+1){1'b0}}, {(P-1){1'b1}}});
  localparam logic signed [PW-1:0] POS_MIN =
    signed'({{(PW-P+1){1'b1}}, {(P-1){1'b0}}});
  localparam logic signed [PW-1:0] DUTY_MAX = PW'(DUTY_LIMIT_Q12);
  localparam logic signed [PW-1:0] DUTY_MIN = -DUTY_MAX;
  localparam logic signed [SETPT_W-1:0] SP_MAX = SETPT_W'(DUTY_LIMIT);
  localparam logic signed [SETPT_W-1:0] SP_MIN = -SP_MAX;

  // Division by a power of two that truncates toward zero.
  function automatic logic signed [PW-1:0] div_pow2(input logic signed [PW-1:0] x,
                                                    input int unsigned sh);
    logic [PW-1:0] bias;
    bias = x[PW-1] ? ((PW'(1) << sh) - PW'(1)) : '0;
    return (x + signed'(bias)) >>> sh;
  endfunction

  // Saturation to the position width.
  function automatic logic signed [P-1:0] sat_pos(input logic signed [PW-1:0] x);
    logic signed [PW-1:0] y;
    y = (x > POS_MAX) ? POS_MAX : ((x < POS_MIN) ? POS_MIN : x);
    return y[P-1:0];
  endfunction

  // Clamp of a Q4.12 duty to the duty limit.
  function automatic logic signed [CLAMP_W-1:0] clamp_duty(input logic signed [PW-1:0] x);
    logic signed [PW-1:0] y;
    y = (x > DUTY_MAX) ? DUTY_MAX : ((x < DUTY_MIN) ? DUTY_MIN : x);
    return y[CLAMP_W-1:0];
  endfunction

  // Clamped Q4.12 duty to whole percent, truncated toward zero.
  function automatic logic signed [DUTY_W-1:0] duty_pct(input logic signed [CLAMP_W-1:0] c);
    logic signed [CLAMP_W-1:0] t;
    logic signed [CLAMP_W-1:0] s;
    t = c + (c[CLAMP_W-1] ? CLAMP_W'((1 << Q12_FRAC) - 1) : '0);
    s = t >>> Q12_FRAC;
    return s[DUTY_W-1:0];
  endfunction

  function automatic logic signed [PW-1:0] ext_pos(input logic signed [P-1:0] x);
    return {{(PW-P){x[P-1]}}, x};
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers. The port never stalls; writes to indexes past
  // the last register are taken and dropped.
  // --------------------------------------------------------------------------
  logic signed [GAIN_W-1:0] kp_q, kd_q;
  logic [SCALE_W-1:0]       factor_q, dscale_q, tscale_q;
  logic [STEP_W-1:0]        step_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q     <= '0;
      kd_q     <= '0;
      factor_q <= FACTOR_RST;
      step_q   <= STEP_RST;
      dscale_q <= DSCALE_RST;
      tscale_q <= TSCALE_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_KP:     kp_q     <= signed'(cfg_data_i);
        CFG_KD:     kd_q     <= signed'(cfg_data_i);
        CFG_FACTOR: factor_q <= cfg_data_i;
        CFG_STEP:   step_q   <= cfg_data_i[STEP_W-1:0];
        CFG_DSCALE: dscale_q <= cfg_data_i;
        CFG_TSCALE: tscale_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer. A request is taken only in the idle state. A drive tick walks
  // through the distance, error and PD steps, a turn through its target
  // steps, and every request ends in the finish state, which commits the
  // controller state and loads the result register. The finish state holds
  // while an earlier result still waits to be taken.
  // --------------------------------------------------------------------------
  state_e state_q, state_d;
  logic   out_valid_q;
  logic   in_fire, fin_fire;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign fin_fire   = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);

  // Controller state.
  logic                     mode_q, mode_d;
  logic signed [RAMP_W-1:0] setpt_q, setpt_d;
  logic signed [RAMP_W-1:0] ramp_q, ramp_d;
  logic signed [P-1:0]      prev_q, prev_d;
  logic signed [P-1:0]      lerr_q, lerr_d;
  logic signed [P-1:0]      ldist_q, ldist_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (opcode_i == OP_TICK && mode_q) begin
            state_d = ST_SUM;
          end else if (opcode_i == OP_TURN) begin
            state_d = ST_TMUL;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_SUM:   state_d = ST_HALF;
      ST_HALF:  state_d = ST_MDIST;
      ST_MDIST: state_d = ST_MERR;
      ST_MERR:  state_d = ST_ERRA;
      ST_ERRA:  state_d = ST_ERRB;
      ST_ERRB:  state_d = ST_DIFF;
      ST_DIFF:  state_d = ST_MKP;
      ST_MKP:   state_d = ST_MKD;
      ST_MKD:   state_d = ST_PD;
      ST_PD:    state_d = ST_DUTYL;
      ST_DUTYL: state_d = ST_DUTYR;
      ST_DUTYR: state_d = ST_FIN;
      ST_TMUL:  state_d = ST_TDIV;
      ST_TDIV:  state_d = ST_TSAT;
      ST_TSAT:  state_d = ST_FIN;
      ST_FIN: begin
        if (fin_fire) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Request registers and the shared multiplier.
  // --------------------------------------------------------------------------
  op_e                       op_q;
  logic signed [P-1:0]       lp_q, rp_q;
  logic signed [SETPT_W-1:0] sp_q;
  logic signed [ANGLE_W-1:0] ang_q;

  logic signed [MA-1:0]      mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic                      mul_en;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [PW-1:0]      prod_x;

  logic signed [PW-1:0]      acc_q;
  logic signed [P-1:0]       dist_q, err_q;
  logic signed [PW-1:0]      pd_q;
  logic signed [CLAMP_W-1:0] cl_q, cr_q;
  logic signed [P-1:0]       lt_q, rt_q;
  logic signed [PW-1:0]      base;

  // Operand selection: distance product, left correction product, the two
  // gain products and the turn product all share the one multiplier.
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    unique case (state_q)
      ST_MDIST: begin
        mul_a = acc_q[MA-1:0];
        mul_b = signed'({1'b0, dscale_q});
      end
      ST_MERR: begin
        mul_a = {{(MA-P){lp_q[P-1]}}, lp_q};
        mul_b = signed'({1'b0, factor_q});
      end
      ST_MKP: begin
        mul_a = {{(MA-P){err_q[P-1]}}, err_q};
        mul_b = {kp_q[GAIN_W-1], kp_q};
      end
      ST_MKD: begin
        mul_a = acc_q[MA-1:0];
        mul_b = {kd_q[GAIN_W-1], kd_q};
      end
      ST_TMUL: begin
        mul_a = {{(MA-ANGLE_W){ang_q[ANGLE_W-1]}}, ang_q};
        mul_b = signed'({1'b0, tscale_q});
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  ddpsc_mul #(
    .A_W (MA),
    .B_W (MUL_B_W)
  ) u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign prod_x = {{(PW-PROD_W){mul_p[PROD_W-1]}}, mul_p};

  // The ramp is Q8.8 and the PD term Q4.12, so the ramp moves up four bits.
  assign base = {{(PW-RAMP_W){ramp_q[RAMP_W-1]}}, ramp_q} <<< BASE_SHIFT;

  // Datapath registers; one operation per step.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= opcode_i;
      lp_q  <= left_position_i;
      rp_q  <= right_position_i;
      sp_q  <= duty_setpoint_i;
      ang_q <= turn_angle_i;
    end
    unique case (state_q)
      // Distance uses the negated half sum of both wheels.
      ST_SUM:   acc_q  <= ext_pos(lp_q) + ext_pos(rp_q);
      ST_HALF:  acc_q  <= '0 - div_pow2(acc_q, 1);
      ST_MERR:  dist_q <= sat_pos(div_pow2(prod_x, Q16_FRAC));
      // Balance error: corrected left position minus the right one.
      ST_ERRA:  acc_q  <= div_pow2(prod_x, Q14_FRAC);
      ST_ERRB:  err_q  <= sat_pos(acc_q - ext_pos(rp_q));
      ST_DIFF:  acc_q  <= ext_pos(err_q) - ext_pos(prev_q);
      ST_MKD:   pd_q   <= prod_x;
      ST_PD:    pd_q   <= pd_q + prod_x;
      // The PD term is taken off the left wheel and added on the right.
      ST_DUTYL: cl_q   <= clamp_duty(base - pd_q);
      ST_DUTYR: cr_q   <= clamp_duty(base + pd_q);
      ST_TDIV:  acc_q  <= div_pow2(prod_x, Q12_FRAC);
      ST_TSAT: begin
        lt_q <= sat_pos(acc_q);
        rt_q <= sat_pos('0 - acc_q);
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Finish step: commit of the controller state and the result fields.
  // --------------------------------------------------------------------------
  logic signed [RAMP_W+1:0]  ramp_w, setpt_w, step_w;
  logic signed [RAMP_W+1:0]  ramp_up, ramp_dn;
  logic                      step_up, step_dn;
  logic signed [RAMP_W-1:0]  ramp_next;
  logic signed [SETPT_W-1:0] sp_clamp;
  logic signed [RAMP_W-1:0]  sp_wide;

  logic signed [DUTY_W-1:0]  res_ld, res_rd;
  logic                      res_act;
  logic signed [P-1:0]       res_lt, res_rt;

  // The ramp moves one step toward the setpoint. A step up lands below the
  // setpoint, so a step down can never follow it in the same tick.
  assign ramp_w  = {{2{ramp_q[RAMP_W-1]}}, ramp_q};
  assign setpt_w = {{2{setpt_q[RAMP_W-1]}}, setpt_q};
  assign step_w  = signed'({3'b000, step_q});
  assign step_up = ramp_w < (setpt_w - step_w);
  assign step_dn = ramp_w > (setpt_w + step_w);
  assign ramp_up = ramp_w + step_w;
  assign ramp_dn = ramp_w - step_w;

  always_comb begin
    if (step_up) begin
      ramp_next = ramp_up[RAMP_W-1:0];
    end else if (step_dn) begin
      ramp_next = ramp_dn[RAMP_W-1:0];
    end else begin
      ramp_next = ramp_q;
    end
  end

  // A drive command stores the clamped duty negated in Q8.8.
  assign sp_clamp = (sp_q > SP_MAX) ? SP_MAX : ((sp_q < SP_MIN) ? SP_MIN : sp_q);
  assign sp_wide  = {{(RAMP_W-SETPT_W){sp_clamp[SETPT_W-1]}}, sp_clamp};

  always_comb begin
    mode_d  = mode_q;
    setpt_d = setpt_q;
    ramp_d  = ramp_q;
    prev_d  = prev_q;
    lerr_d  = lerr_q;
    ldist_d = ldist_q;
    res_ld  = '0;
    res_rd  = '0;
    res_act = 1'b0;
    res_lt  = '0;
    res_rt  = '0;
    unique case (op_q)
      OP_TICK: begin
        // A tick while idle changes nothing and reports zero duties.
        if (mode_q) begin
          res_ld  = duty_pct(cl_q);
          res_rd  = duty_pct(cr_q);
          res_act = 1'b1;
          prev_d  = err_q;
          lerr_d  = err_q;
          ldist_d = dist_q;
          ramp_d  = ramp_next;
        end
      end
      OP_DRIVE: begin
        mode_d  = 1'b1;
        setpt_d = ('0 - sp_wide) <<< Q8_FRAC;
      end
      OP_STOP: begin
        // The previous error and the distance survive a stop.
        mode_d  = 1'b0;
        setpt_d = '0;
        ramp_d  = '0;
        lerr_d  = '0;
      end
      OP_TURN: begin
        // The turn itself runs elsewhere; only its targets are reported.
        mode_d  = 1'b0;
        setpt_d = '0;
        ramp_d  = '0;
        res_lt  = lt_q;
        res_rt  = rt_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      mode_q      <= 1'b0;
      setpt_q     <= '0;
      ramp_q      <= '0;
      prev_q      <= '0;
      lerr_q      <= '0;
      ldist_q     <= '0;
    end else begin
      state_q <= state_d;
      if (fin_fire) begin
        out_valid_q <= 1'b1;
        mode_q      <= mode_d;
        setpt_q     <= setpt_d;
        ramp_q      <= ramp_d;
        prev_q      <= prev_d;
        lerr_q      <= lerr_d;
        ldist_q     <= ldist_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register.
  logic signed [DUTY_W-1:0] o_ld_q, o_rd_q;
  logic                     o_act_q, o_mode_q;
  logic signed [P-1:0]      o_dist_q, o_err_q, o_lt_q, o_rt_q;

  always_ff @(posedge clk_i) begin
    if (fin_fire) begin
      o_ld_q   <= res_ld;
      o_rd_q   <= res_rd;
      o_act_q  <= res_act;
      o_dist_q <= ldist_d;
      o_err_q  <= lerr_d;
      o_lt_q   <= res_lt;
      o_rt_q   <= res_rt;
      o_mode_q <= mode_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign left_duty_o          = o_ld_q;
  assign right_duty_o         = o_rd_q;
  assign drive_active_o       = o_act_q;
  assign travelled_distance_o = o_dist_q;
  assign balance_error_o      = o_err_q;
  assign left_turn_target_o   = o_lt_q;
  assign right_turn_target_o  = o_rt_q;
  assign current_mode_o       = o_mode_q;

endmodule

@@ sv/ddpsc_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared signed multiplier
// One signed multiplier with a registered product, loaded when enabled.
// ----------------------------------------------------------------------------
module ddpsc_mul #(
  parameter int unsigned A_W = 26,
  parameter int unsigned B_W = 17
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic signed [A_W-1:0]        a_i,
  input  logic signed [B_W-1:0]        b_i,
  output logic signed [A_W+B_W-1:0]    p_o
);

  logic signed [A_W+B_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= a_i * b_i;
    end
  end

  assign p_o = p_q;

endmodule

@@ verif/drive_check_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Straight-drive checking package
// Request and result records plus a scoreboard that predicts the controller
// output for every accepted request and compares it with what comes back.
// ----------------------------------------------------------------------------
package drive_check_pkg;
  import ddpsc_pkg::*;

  localparam int     POS_W        = 24;
  localparam longint POS_MAX      = (longint'(1) <<< (POS_W - 1)) - 1;
  localparam longint POS_MIN      = -POS_MAX - 1;
  localparam int     REPORT_LIMIT = 10;

  typedef struct {
    op_e                      op;
    logic signed [POS_W-1:0]  left_pos;
    logic signed [POS_W-1:0]  right_pos;
    logic signed [SETPT_W-1:0] setpoint;
    logic signed [ANGLE_W-1:0] angle;
  } drive_request_t;

  typedef struct packed {
    logic signed [DUTY_W-1:0] left_duty;
    logic signed [DUTY_W-1:0] right_duty;
    logic                     drive_active;
    logic signed [POS_W-1:0]  travelled_distance;
    logic signed [POS_W-1:0]  balance_error;
    logic signed [POS_W-1:0]  left_turn_target;
    logic signed [POS_W-1:0]  right_turn_target;
    logic                     current_mode;
  } drive_result_t;

  function automatic longint clamp_to(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Q4.12 duty to whole percent, saturated and truncated toward zero.
  function automatic longint duty_from_q12(longint q12);
    return clamp_to(q12, -DUTY_LIMIT_Q12, DUTY_LIMIT_Q12) / 4096;
  endfunction

  class drive_scoreboard;
    longint kp_gain, kd_gain, balance_factor, ramp_increment;
    longint mm_per_degree, turn_degrees;
    bit     driving;
    longint setpoint_q8, ramp_q8, prior_error, held_error, held_distance;
    drive_result_t due_results[$];
    int errors;

    function new();
      kp_gain        = 0;
      kd_gain        = 0;
      balance_factor = FACTOR_RST;
      ramp_increment = STEP_RST;
      mm_per_degree  = DSCALE_RST;
      turn_degrees   = TSCALE_RST;
      driving        = 1'b0;
      setpoint_q8    = 0;
      ramp_q8        = 0;
      prior_error    = 0;
      held_error     = 0;
      held_distance  = 0;
      errors         = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_KP:     kp_gain = $signed(data);
        CFG_KD:     kd_gain = $signed(data);
        CFG_FACTOR: balance_factor = data;
        CFG_STEP:   ramp_increment = data[STEP_W-1:0];
        CFG_DSCALE: mm_per_degree = data;
        CFG_TSCALE: turn_degrees = data;
        default: ;
      endcase
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void note_request(drive_request_t req);
      longint lp, rp, setpt, ang, err, pd, base, target;
      drive_result_t res;
      lp    = req.left_pos;
      rp    = req.right_pos;
      ang   = req.angle;
      setpt = clamp_to(req.setpoint, -DUTY_LIMIT, DUTY_LIMIT);
      res   = '0;
      case (req.op)
        OP_TICK: begin
          if (driving) begin
            held_distance = clamp_to((-((lp + rp) / 2)) * mm_per_degree / 65536,
                                     POS_MIN, POS_MAX);
            err  = clamp_to(lp * balance_factor / 16384 - rp, POS_MIN, POS_MAX);
            pd   = kp_gain * err + kd_gain * (err - prior_error);
            base = ramp_q8 * 16;
            prior_error = err;
            held_error  = err;
            res.left_duty    = DUTY_W'(duty_from_q12(base - pd));
            res.right_duty   = DUTY_W'(duty_from_q12(base + pd));
            res.drive_active = 1'b1;
            if (ramp_q8 < setpoint_q8 - ramp_increment) ramp_q8 += ramp_increment;
            if (ramp_q8 > setpoint_q8 + ramp_increment) ramp_q8 -= ramp_increment;
          end
        end
        OP_DRIVE: begin
          driving     = 1'b1;
          setpoint_q8 = -setpt * 256;
        end
        OP_STOP: begin
          driving     = 1'b0;
          setpoint_q8 = 0;
          ramp_q8     = 0;
          held_error  = 0;
        end
        OP_TURN: begin
          driving     = 1'b0;
          setpoint_q8 = 0;
          ramp_q8     = 0;
          target      = ang * turn_degrees / 4096;
          res.left_turn_target  = POS_W'(clamp_to(target, POS_MIN, POS_MAX));
          res.right_turn_target = POS_W'(clamp_to(-target, POS_MIN, POS_MAX));
        end
        default: ;
      endcase
      res.travelled_distance = POS_W'(held_distance);
      res.balance_error      = POS_W'(held_error);
      res.current_mode       = driving;
      due_results.push_back(res);
    endfunction

    function void check_result(drive_result_t got);
      drive_result_t want;
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: result with no request waiting: L=%0d R=%0d",
                   $realtime, got.left_duty, got.right_duty);
        return;
      end
      want = due_results.pop_front();
      if (got.left_duty !== want.left_duty || got.right_duty !== want.right_duty ||
          got.drive_active !== want.drive_active ||
          got.travelled_distance !== want.travelled_distance ||
          got.balance_error !== want.balance_error ||
          got.left_turn_target !== want.left_turn_target ||
          got.right_turn_target !== want.right_turn_target ||
          got.current_mode !== want.current_mode) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $display("%0t: mismatch, expected duty %0d/%0d act %0b dist %0d err %0d tgt %0d/%0d mode %0b",
                   $realtime, want.left_duty, want.right_duty, want.drive_active,
                   want.travelled_distance, want.balance_error, want.left_turn_target,
                   want.right_turn_target, want.current_mode);
          $display("%0t:           got      duty %0d/%0d act %0b dist %0d err %0d tgt %0d/%0d mode %0b",
                   $realtime, got.left_duty, got.right_duty, got.drive_active,
                   got.travelled_distance, got.balance_error, got.left_turn_target,
                   got.right_turn_target, got.current_mode);
        end
      end
    endfunction

    function void finish_check();
      if (due_results.size() != 0) begin
        $display("%0d results never arrived", due_results.size());
        errors += due_results.size();
      end
    endfunction
  endclass

endpackage

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Straight-drive controller testbench
// Drives control ticks, drive, stop and turn requests through the valid and
// ready channels, predicts each result in a scoreboard and compares them in
// order, over several register settings and sender and receiver idle mixes.
// ----------------------------------------------------------------------------
module tb_top;
  import ddpsc_pkg::*;
  import drive_check_pkg::*;

  localparam int          RESET_CYCLES  = 7;
  // Drain time that covers the slowest request, a drive tick.
  localparam int          DRAIN_CYCLES  = 16;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          PHASE_COUNT   = 8;
  localparam int          PHASE_ITEMS   = 244;
  localparam int unsigned TIMEOUT_NS    = 5_000_000;
  // Register indexes beyond the defined set; the block must ignore them.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  logic clk;
  logic rst_ni;

  logic                       cfg_valid_i;
  logic                       cfg_ready_o;
  logic [CFG_IDX_W-1:0]       cfg_index_i;
  logic [CFG_DATA_W-1:0]      cfg_data_i;

  logic                       in_valid_i;
  logic                       in_ready_o;
  op_e                        opcode_i;
  logic signed [POS_W-1:0]    left_position_i;
  logic signed [POS_W-1:0]    right_position_i;
  logic signed [SETPT_W-1:0]  duty_setpoint_i;
  logic signed [ANGLE_W-1:0]  turn_angle_i;

  logic                       out_valid_o;
  logic                       out_ready_i;
  logic signed [DUTY_W-1:0]   left_duty_o;
  logic signed [DUTY_W-1:0]   right_duty_o;
  logic                       drive_active_o;
  logic signed [POS_W-1:0]    travelled_distance_o;
  logic signed [POS_W-1:0]    balance_error_o;
  logic signed [POS_W-1:0]    left_turn_target_o;
  logic signed [POS_W-1:0]    right_turn_target_o;
  logic                       current_mode_o;

  drive_scoreboard board;
  drive_result_t   observed;

  // Idle mix of the current phase, in percent.
  int unsigned sender_gap_pct;
  int unsigned receiver_stall_pct;
  // Set by the stimulus to ask the receiver for one long hold-off.
  bit          hold_request = 1'b0;
  int          hold_left;

  // Random request generator state: a rough copy of the mode, so that most
  // ticks land while driving, and slowly moving wheel positions.
  bit                      gen_driving = 1'b0;
  logic signed [POS_W-1:0] walk_left   = '0;
  logic signed [POS_W-1:0] walk_right  = '0;

  differential_drive_pd_straight_control #(
    .POSITION_BITS(POS_W)
  ) dut (
    .clk_i               (clk),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .opcode_i            (opcode_i),
    .left_position_i     (left_position_i),
    .right_position_i    (right_position_i),
    .duty_setpoint_i     (duty_setpoint_i),
    .turn_angle_i        (turn_angle_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .left_duty_o         (left_duty_o),
    .right_duty_o        (right_duty_o),
    .drive_active_o      (drive_active_o),
    .travelled_distance_o(travelled_distance_o),
    .balance_error_o     (balance_error_o),
    .left_turn_target_o  (left_turn_target_o),
    .right_turn_target_o (right_turn_target_o),
    .current_mode_o      (current_mode_o)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the run; several times the slowest legal run.
  initial begin
    #TIMEOUT_NS;
    $display("DONE: errors detected");
    $finish;
  end

  // Receiver: decides out_ready at each falling edge. A long hold-off, once
  // asked for, is counted down here and overrides the random stalls.
  initial begin
    out_ready_i = 1'b0;
    hold_left   = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready_i = 1'b0;
        hold_left--;
      end else begin
        out_ready_i = ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  // Every result taken at a rising edge is checked against the oldest
  // prediction.
  always @(posedge clk) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      observed.left_duty          = left_duty_o;
      observed.right_duty         = right_duty_o;
      observed.drive_active       = drive_active_o;
      observed.travelled_distance = travelled_distance_o;
      observed.balance_error      = balance_error_o;
      observed.left_turn_target   = left_turn_target_o;
      observed.right_turn_target  = right_turn_target_o;
      observed.current_mode       = current_mode_o;
      board.check_result(observed);
    end
  end

  // One register write over the configuration channel.
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk); while (!cfg_ready_o);
    board.write_register(idx, data);
    @(negedge clk);
    cfg_valid_i = 1'b0;
  endtask

  // Offers one request, possibly after some idle cycles, and waits until the
  // block takes it. Valid stays high afterwards so back-to-back requests
  // need no gap; the next call lowers it only if it idles.
  task automatic send_item(drive_request_t req);
    @(negedge clk);
    while ($urandom_range(99) < sender_gap_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk);
    end
    in_valid_i       = 1'b1;
    opcode_i         = req.op;
    left_position_i  = req.left_pos;
    right_position_i = req.right_pos;
    duty_setpoint_i  = req.setpoint;
    turn_angle_i     = req.angle;
    do @(posedge clk); while (!in_ready_o);
    board.note_request(req);
  endtask

  task automatic send_fields(op_e op, logic signed [POS_W-1:0] lp,
                             logic signed [POS_W-1:0] rp,
                             logic signed [SETPT_W-1:0] setpt,
                             logic signed [ANGLE_W-1:0] ang);
    drive_request_t req;
    req.op        = op;
    req.left_pos  = lp;
    req.right_pos = rp;
    req.setpoint  = setpt;
    req.angle     = ang;
    send_item(req);
  endtask

  // Stops offering, waits for every predicted result, then lets the block
  // finish anything still in flight so that registers may be written.
  task automatic settle_block();
    @(negedge clk);
    in_valid_i = 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [POS_W-1:0] corner_value();
    case ($urandom_range(3))
      0:       return POS_W'(POS_MAX);
      1:       return POS_W'(POS_MIN);
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // Mostly well-formed drive sessions: a drive request, a run of ticks with
  // wheels that creep forward at nearly the same rate, then a stop or turn.
  // A few items jump to arbitrary or extreme positions.
  function automatic drive_request_t next_random_request();
    drive_request_t req;
    int unsigned    pick;
    int             delta;
    pick = $urandom_range(99);
    if (!gen_driving) begin
      req.op = (pick < 45) ? OP_DRIVE : (pick < 85) ? OP_TICK :
               (pick < 93) ? OP_STOP : OP_TURN;
    end else begin
      req.op = (pick < 88) ? OP_TICK : (pick < 93) ? OP_DRIVE :
               (pick < 97) ? OP_STOP : OP_TURN;
    end
    if (req.op == OP_DRIVE) gen_driving = 1'b1;
    if (req.op == OP_STOP || req.op == OP_TURN) gen_driving = 1'b0;

    pick = $urandom_range(99);
    if (pick < 6) begin
      walk_left  = POS_W'($urandom);
      walk_right = POS_W'($urandom);
    end else if (pick < 9) begin
      walk_left  = corner_value();
      walk_right = corner_value();
    end else begin
      delta      = int'($urandom_range(0, 30)) - 5;
      walk_left  = POS_W'(walk_left + delta);
      walk_right = POS_W'(walk_right + delta + int'($urandom_range(0, 6)) - 3);
    end
    req.left_pos  = walk_left;
    req.right_pos = walk_right;
    // Setpoints beyond +/-100 must be clamped by the block.
    req.setpoint  = ($urandom_range(99) < 85) ? 8'(int'($urandom_range(0, 200)) - 100)
                                              : 8'($urandom);
    req.angle     = ANGLE_W'($urandom);
    return req;
  endfunction

  // Register settings per phase: all maxima, all minima, then random values
  // that mostly keep the gains small so the duties do not simply saturate.
  task automatic configure_phase(int ph);
    logic [CFG_DATA_W-1:0] kp, kd, fac, stp, dsc, tsc;
    case (ph)
      0: begin
        kp = 16'h7FFF; kd = 16'h7FFF; fac = 16'hFFFF;
        stp = 16'h7FFF; dsc = 16'hFFFF; tsc = 16'hFFFF;
      end
      1: begin
        kp = 16'h8000; kd = 16'h8000; fac = '0;
        stp = '0; dsc = '0; tsc = '0;
      end
      default: begin
        kp  = ($urandom_range(3) == 0) ? 16'($urandom) : 16'(int'($urandom_range(0, 6000)) - 3000);
        kd  = ($urandom_range(3) == 0) ? 16'($urandom) : 16'(int'($urandom_range(0, 2000)) - 1000);
        fac = ($urandom_range(3) == 0) ? 16'($urandom)
                                       : 16'(16384 + int'($urandom_range(0, 1000)) - 500);
        stp = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(16, 3000));
        dsc = 16'($urandom);
        tsc = 16'($urandom);
      end
    endcase
    write_register(CFG_KP, kp);
    write_register(CFG_KD, kd);
    write_register(CFG_FACTOR, fac);
    write_register(CFG_STEP, stp);
    write_register(CFG_DSCALE, dsc);
    write_register(CFG_TSCALE, tsc);
  endtask

  initial begin
    rst_ni             = 1'b0;
    cfg_valid_i        = 1'b0;
    cfg_index_i        = CFG_KP;
    cfg_data_i         = '0;
    in_valid_i         = 1'b0;
    opcode_i           = OP_TICK;
    left_position_i    = '0;
    right_position_i   = '0;
    duty_setpoint_i    = '0;
    turn_angle_i       = '0;
    sender_gap_pct     = 0;
    receiver_stall_pct = 0;
    board = new();

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    // Gains of one and minus one half, a fast ramp of 50 percent per tick,
    // and writes to the unused indexes, which must change nothing.
    write_register(CFG_KP, 16'd4096);
    write_register(CFG_KD, 16'hF800);
    write_register(CFG_FACTOR, 16'd16384);
    write_register(CFG_STEP, 16'd12800);
    write_register(CFG_DSCALE, 16'd1000);
    write_register(CFG_TSCALE, 16'd4096);
    write_register(CFG_SPARE_LO, 16'hFFFF);
    write_register(CFG_SPARE_HI, 16'h5A5A);

    // Directed requests: a tick while idle, turns at the angle extremes,
    // setpoints beyond the duty limit, ticks at the position extremes, a
    // stop that keeps the old error for the derivative, and ticks after
    // stop and turn that must leave the state alone.
    send_fields(OP_TICK,  24'sd100, 24'sd50, 8'sd0, 16'sd0);
    send_fields(OP_TURN,  '0, '0, 8'sd0, 16'sh7FFF);
    send_fields(OP_TURN,  '0, '0, 8'sd0, 16'sh8000);
    send_fields(OP_TURN,  '0, '0, 8'sd0, 16'sd0);
    send_fields(OP_DRIVE, '0, '0, 8'sh7F, 16'sd0);
    send_fields(OP_TICK,  24'sd0, 24'sd0, 8'sd0, 16'sd0);
    send_fields(OP_TICK,  24'sd10, 24'sd3, 8'sd0, 16'sd0);
    send_fields(OP_TICK,  POS_W'(POS_MAX), POS_W'(POS_MAX), 8'sd0, 16'sd0);
    send_fields(OP_TICK,  POS_W'(POS_MIN), POS_W'(POS_MIN), 8'sd0, 16'sd0);
    send_fields(OP_TICK,  POS_W'(POS_MAX), POS_W'(POS_MIN), 8'sd0, 16'sd0);
    send_fields(OP_TICK,  POS_W'(POS_MIN), POS_W'(POS_MAX), 8'sd0, 16'sd0);
    send_fields(OP_DRIVE, '0, '0, 8'sh80, 16'sd0);
    send_fields(OP_TICK,  24'sd100, 24'sd100, 8'sd0, 16'sd0);
    send_fields(OP_TICK,  24'sd120, 24'sd90, 8'sd0, 16'sd0);
    send_fields(OP_DRIVE, '0, '0, 8'sd100, 16'sd0);
    send_fields(OP_DRIVE, '0, '0, -8'sd100, 16'sd0);
    send_fields(OP_TICK,  24'sd200, 24'sd205, 8'sd0, 16'sd0);
    send_fields(OP_STOP,  '0, '0, 8'sd0, 16'sd0);
    send_fields(OP_TICK,  24'sd300, 24'sd280, 8'sd0, 16'sd0);
    send_fields(OP_DRIVE, '0, '0, 8'sd0, 16'sd0);
    send_fields(OP_TICK,  -24'sd1, -24'sd1, 8'sd0, 16'sd0);
    send_fields(OP_TURN,  '0, '0, 8'sd0, 16'sd100);
    send_fields(OP_TICK,  24'sd5, 24'sd5, 8'sd0, 16'sd0);

    // Random phases. Each one starts from an idle block with new register
    // values and cycles through the idle mixes; the phases without random
    // idling also hold the receiver off long enough to back up the input.
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      settle_block();
      configure_phase(ph);
      case (ph % 4)
        0:       begin sender_gap_pct = 0;  receiver_stall_pct = 0;  end
        1:       begin sender_gap_pct = 62; receiver_stall_pct = 0;  end
        2:       begin sender_gap_pct = 0;  receiver_stall_pct = 62; end
        default: begin sender_gap_pct = 26; receiver_stall_pct = 26; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ((ph % 4) == 0 && n == 40) hold_request = 1'b1;
        send_item(next_random_request());
      end
    end

    settle_block();
    board.finish_check();
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/ddpsc_pkg.sv
sv/ddpsc_mul.sv
sv/differential_drive_pd_straight_control.sv
verif/drive_check_pkg.sv
verif/tb_top.sv
